/* design/buddy_block_allocator_assert.svh */
// assertion macros used by the buddy allocator top level
`ifndef BUDDY_BLOCK_ALLOCATOR_ASSERT_SVH
`define BUDDY_BLOCK_ALLOCATOR_ASSERT_SVH

// condition must hold at every clock edge out of reset
`define BBA_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define BBA_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define BBA_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/bba_pkg.sv */
// shared types and constants of the buddy block allocator
`timescale 1ns / 1ps
package bba_pkg;

  localparam int NUM_PAGES_DEF  = 4;
  localparam int PAGE_ORDER_DEF = 12;
  localparam int MIN_ORDER_DEF  = 4;

  localparam int ADDR_FIELD_W = 10;
  localparam int SIZE_FIELD_W = 13;
  localparam int ORD_FIELD_W  = 4;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TOO_BIG  = 2'd1;
  localparam logic [1:0] ST_NO_MEM   = 2'd2;
  localparam logic [1:0] ST_BAD_FREE = 2'd3;

  typedef struct packed {
    logic                    func;
    logic [SIZE_FIELD_W-1:0] req_size;
    logic [ADDR_FIELD_W-1:0] block_address;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_FIELD_W-1:0] granted_address;
    logic [ORD_FIELD_W-1:0]  granted_order;
    logic [1:0]              status;
  } out_item_t;

  // one block table entry, order kept relative to the granule order
  typedef struct packed {
    logic       valid;
    logic       used;
    logic [3:0] rel;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

/* design/buddy_block_allocator.sv */
// buddy block allocator top level: sequencer, page map and block table
//
// usage: one request beat on in_* (allocate or free), one result beat on out_*.
// cfg_wr_en/cfg_wr_data write fit_mode (0 smallest fit, 1 first fit); the user
// must write it only while idle; the block itself does not enforce it.
// after reset the block table is cleared one entry a cycle with in_stall high.
// one request is worked at a time; in_stall stays high until it is done.
// allocate: one table entry read per cycle in a pipelined scan of the table,
// which first fit stops at the first hit, then a pick step and one split step
// per split level; an oversize request skips the scan.
// free: a check of the block, then a merge step and a buddy check per buddy
// tried, no buddy check once it is a whole page; the table has one read port.
// the result sits in an output register; while out_stall holds it there,
// a finished request waits and no new request is taken.
// reset clears the page map and fit_mode and drops any pending result.
`timescale 1ns / 1ps
`include "buddy_block_allocator_assert.svh"
module buddy_block_allocator #(
  parameter int NUM_PAGES  = bba_pkg::NUM_PAGES_DEF,
  parameter int PAGE_ORDER = bba_pkg::PAGE_ORDER_DEF,
  parameter int MIN_ORDER  = bba_pkg::MIN_ORDER_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  bba_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output bba_pkg::out_item_t out_data,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data
);
  import bba_pkg::*;

  localparam int SPAN   = PAGE_ORDER - MIN_ORDER;
  localparam int TOTAL  = NUM_PAGES << SPAN;
  localparam int ADDR_W = $clog2(TOTAL);
  localparam int CNT_W  = ADDR_W + 1;
  localparam int PG_W   = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_SCAN  = 10'b0000000100,
    S_PICK  = 10'b0000001000,
    S_SPLIT = 10'b0000010000,
    S_FCHK  = 10'b0000100000,
    S_MERGE = 10'b0001000000,
    S_BCHK  = 10'b0010000000,
    S_DONE  = 10'b0100000000,
    S_SPARE = 10'b1000000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   clr_r, clr_nxt;
  logic [CNT_W-1:0]    scan_r, scan_nxt;
  logic                chk_vld_r, chk_vld_nxt;
  logic [ADDR_W-1:0]   chk_addr_r, chk_addr_nxt;
  logic                found_r, found_nxt;
  logic [ADDR_W-1:0]   pick_r, pick_nxt;
  logic [3:0]          rel_r, rel_nxt;
  logic [3:0]          need_r, need_nxt;
  logic [ADDR_W-1:0]   bud_r, bud_nxt;
  logic [NUM_PAGES-1:0] page_r, page_nxt;
  logic                fit_mode_r;
  out_item_t           res_r, res_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_r, out_nxt;

  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
  entry_t              mem_wdata, mem_rdata;
  logic [ENTRY_W-1:0]  rdata_raw;

  logic                accept;
  logic [3:0]          req_need;
  logic                req_big;
  logic                page_free;
  logic [PG_W-1:0]     page_idx;
  logic [PG_W-1:0]     rel_page;
  logic                cand, better;

  bba_ram #(.WIDTH(ENTRY_W), .DEPTH(TOTAL)) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rdata_raw)
  );
  assign mem_rdata = entry_t'(rdata_raw);

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // size to order, smallest order whose block holds the size
  always_comb begin
    req_need = 4'(SPAN);
    for (int k = SPAN; k >= 0; k--) begin
      if ((32'(1) << (MIN_ORDER + k)) >= 32'(in_data.req_size)) begin
        req_need = 4'(k);
      end
    end
    req_big = 32'(in_data.req_size) > (32'(1) << PAGE_ORDER);
  end

  // lowest absent page
  always_comb begin
    page_free = 1'b0;
    page_idx  = '0;
    for (int p = NUM_PAGES - 1; p >= 0; p--) begin
      if (!page_r[p]) begin
        page_free = 1'b1;
        page_idx  = PG_W'(p);
      end
    end
  end

  assign rel_page = PG_W'(chk_addr_r >> SPAN);
  assign cand   = chk_vld_r && mem_rdata.valid && !mem_rdata.used &&
                  (mem_rdata.rel >= need_r);
  assign better = cand && (!found_r || (mem_rdata.rel < rel_r));

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    scan_nxt      = scan_r;
    chk_vld_nxt   = 1'b0;
    chk_addr_nxt  = chk_addr_r;
    found_nxt     = found_r;
    pick_nxt      = pick_r;
    rel_nxt       = rel_r;
    need_nxt      = need_r;
    bud_nxt       = bud_r;
    page_nxt      = page_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    mem_we        = 1'b0;
    mem_waddr     = clr_r;
    mem_wdata     = '0;
    mem_raddr     = scan_r[ADDR_W-1:0];

    unique case (state_r)
      S_CLEAR: begin
        mem_we  = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == ADDR_W'(TOTAL - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        mem_raddr = ADDR_W'(in_data.block_address);
        res_nxt   = '0;
        if (accept) begin
          if (in_data.func == FUNC_ALLOC) begin
            need_nxt  = req_need;
            scan_nxt  = '0;
            found_nxt = 1'b0;
            if (req_big) begin
              res_nxt.status = ST_TOO_BIG;
              state_nxt      = S_DONE;
            end else begin
              state_nxt = S_SCAN;
            end
          end else if (32'(in_data.block_address) >= 32'(TOTAL)) begin
            res_nxt.status = ST_BAD_FREE;
            state_nxt      = S_DONE;
          end else begin
            chk_addr_nxt = ADDR_W'(in_data.block_address);
            state_nxt    = S_FCHK;
          end
        end
      end
      S_SCAN: begin
        // read one entry a cycle, check the one read the cycle before
        if (scan_r < CNT_W'(TOTAL)) begin
          scan_nxt     = scan_r + 1'b1;
          chk_vld_nxt  = 1'b1;
          chk_addr_nxt = scan_r[ADDR_W-1:0];
        end
        if (better) begin
          found_nxt = 1'b1;
          pick_nxt  = chk_addr_r;
          rel_nxt   = mem_rdata.rel;
        end
        if ((better && fit_mode_r) || (!chk_vld_nxt && !chk_vld_r)) begin
          chk_vld_nxt = 1'b0;
          state_nxt   = S_PICK;
        end
      end
      S_PICK: begin
        if (found_r) begin
          state_nxt = S_SPLIT;
        end else if (!page_free) begin
          res_nxt.status = ST_NO_MEM;
          state_nxt      = S_DONE;
        end else begin
          page_nxt[page_idx] = 1'b1;
          pick_nxt  = ADDR_W'(page_idx) << SPAN;
          rel_nxt   = 4'(SPAN);
          state_nxt = S_SPLIT;
        end
      end
      S_SPLIT: begin
        mem_we = 1'b1;
        if (rel_r > need_r) begin
          // upper half becomes a free block one order down
          rel_nxt         = rel_r - 1'b1;
          mem_waddr       = pick_r | (ADDR_W'(1) << (rel_r - 1'b1));
          mem_wdata.valid = 1'b1;
          mem_wdata.rel   = rel_r - 1'b1;
        end else begin
          mem_waddr               = pick_r;
          mem_wdata.valid         = 1'b1;
          mem_wdata.used          = 1'b1;
          mem_wdata.rel           = rel_r;
          res_nxt.granted_address = ADDR_FIELD_W'(pick_r);
          res_nxt.granted_order   = ORD_FIELD_W'(32'(rel_r) + MIN_ORDER);
          res_nxt.status          = ST_OK;
          state_nxt               = S_DONE;
        end
      end
      S_FCHK: begin
        if (!mem_rdata.valid || !mem_rdata.used) begin
          res_nxt.status = ST_BAD_FREE;
          state_nxt      = S_DONE;
        end else begin
          rel_nxt   = mem_rdata.rel;
          state_nxt = S_MERGE;
        end
      end
      S_MERGE: begin
        bud_nxt   = chk_addr_r ^ (ADDR_W'(1) << rel_r);
        mem_raddr = bud_nxt;
        if (rel_r < 4'(SPAN)) begin
          state_nxt = S_BCHK;
        end else begin
          // whole page free again
          mem_we             = 1'b1;
          mem_waddr          = chk_addr_r;
          page_nxt[rel_page] = 1'b0;
          res_nxt.status     = ST_OK;
          state_nxt          = S_DONE;
        end
      end
      S_BCHK: begin
        mem_we = 1'b1;
        if (mem_rdata.valid && !mem_rdata.used && (mem_rdata.rel == rel_r)) begin
          // the upper of the pair stops being a block start
          mem_waddr = (bud_r > chk_addr_r) ? bud_r : chk_addr_r;
          if (bud_r < chk_addr_r) begin
            chk_addr_nxt = bud_r;
          end
          rel_nxt   = rel_r + 1'b1;
          state_nxt = S_MERGE;
        end else begin
          mem_waddr       = chk_addr_r;
          mem_wdata.valid = 1'b1;
          mem_wdata.rel   = rel_r;
          res_nxt.status  = ST_OK;
          state_nxt       = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_nxt       = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      chk_vld_r   <= 1'b0;
      page_r      <= '0;
      fit_mode_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      chk_vld_r   <= chk_vld_nxt;
      page_r      <= page_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        fit_mode_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_r     <= scan_nxt;
    chk_addr_r <= chk_addr_nxt;
    found_r    <= found_nxt;
    pick_r     <= pick_nxt;
    rel_r      <= rel_nxt;
    need_r     <= need_nxt;
    bud_r      <= bud_nxt;
    res_r      <= res_nxt;
    out_r      <= out_nxt;
  end

  `BBA_ALWAYS(a_state_onehot, $onehot(state_r), "state register not one-hot")
  `BBA_SAME(a_no_write_idle, state_r == S_IDLE, !mem_we, "table write while idle")
  `BBA_SAME(a_split_floor, state_r == S_SPLIT, rel_r >= need_r, "split below needed order")
  `BBA_NEXT(a_done_loads, (state_r == S_DONE) && !(out_valid_r && out_stall), out_valid_r && (state_r == S_IDLE), "finished result not loaded")
  `BBA_SAME(a_merge_bound, state_r == S_BCHK, rel_r < 4'(SPAN), "merge beyond page order")

endmodule

/* design/bba_ram.sv */
// generic single write port ram with registered read
`timescale 1ns / 1ps
module bba_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sim/buddy_block_allocator_tb.sv */
// self-checking testbench for the buddy block allocator with randomized traffic
`timescale 1ns / 1ps
module buddy_block_allocator_tb;
  import bba_pkg::*;

  localparam int PAGES    = NUM_PAGES_DEF;
  localparam int PG_ORDER = PAGE_ORDER_DEF;
  localparam int GR_ORDER = MIN_ORDER_DEF;
  localparam int SPAN     = PG_ORDER - GR_ORDER;
  localparam int GRANULES = PAGES << SPAN;
  localparam int STALL_LIMIT = 5000;

  class alloc_scoreboard;
    entry_t     blocks[GRANULES];
    bit         page_in_use[PAGES];
    bit         first_fit;
    out_item_t  pending[$];
    int         mismatches;

    function new();
      foreach (blocks[i]) blocks[i] = '0;
      foreach (page_in_use[i]) page_in_use[i] = 0;
      first_fit = 0;
      mismatches = 0;
    endfunction

    function out_item_t grant(int unsigned bytes);
      out_item_t  r;
      int         ord, need, pick, pick_rel, p;
      bit         hit;
      r = '0;
      ord = GR_ORDER;
      hit = 0;
      pick = 0;
      pick_rel = 0;
      while (ord <= PG_ORDER && (1 << ord) < bytes) ord++;
      if (ord > PG_ORDER) begin
        r.status = ST_TOO_BIG;
        return r;
      end
      need = ord - GR_ORDER;
      for (int g = 0; g < GRANULES; g++) begin
        if (!blocks[g].valid || blocks[g].used || blocks[g].rel < need) continue;
        if (!hit || blocks[g].rel < pick_rel) begin
          hit = 1;
          pick = g;
          pick_rel = blocks[g].rel;
          if (first_fit) break;
        end
      end
      if (!hit) begin
        p = 0;
        while (p < PAGES && page_in_use[p]) p++;
        if (p >= PAGES) begin
          r.status = ST_NO_MEM;
          return r;
        end
        page_in_use[p] = 1;
        pick = p << SPAN;
        pick_rel = SPAN;
      end
      // split, handing the upper halves back as free blocks
      while (pick_rel > need) begin
        pick_rel--;
        blocks[pick + (1 << pick_rel)] = '{valid: 1'b1, used: 1'b0, rel: pick_rel[3:0]};
      end
      blocks[pick] = '{valid: 1'b1, used: 1'b1, rel: pick_rel[3:0]};
      r.granted_address = pick[ADDR_FIELD_W-1:0];
      r.granted_order = ORD_FIELD_W'(pick_rel + GR_ORDER);
      r.status = ST_OK;
      return r;
    endfunction

    function out_item_t release_block(int unsigned addr);
      out_item_t  r;
      int unsigned rel, bud;
      r = '0;
      if (addr >= GRANULES || !blocks[addr].valid || !blocks[addr].used) begin
        r.status = ST_BAD_FREE;
        return r;
      end
      rel = blocks[addr].rel;
      while (rel < SPAN) begin
        bud = addr ^ (1 << rel);
        if (!blocks[bud].valid || blocks[bud].used || blocks[bud].rel != rel) break;
        blocks[addr] = '0;
        blocks[bud] = '0;
        if (bud < addr) addr = bud;
        rel++;
      end
      if (rel >= SPAN) begin
        blocks[addr] = '0;
        page_in_use[(addr >> SPAN) % PAGES] = 0;
      end else begin
        blocks[addr] = '{valid: 1'b1, used: 1'b0, rel: rel[3:0]};
      end
      r.status = ST_OK;
      return r;
    endfunction

    function out_item_t note_request(in_item_t it);
      out_item_t r;
      if (it.func == FUNC_ALLOC) r = grant(it.req_size);
      else r = release_block(it.block_address);
      pending.push_back(r);
      return r;
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
        return;
      end
      want = pending.pop_front();
      if (got.granted_address !== want.granted_address ||
          got.granted_order !== want.granted_order || got.status !== want.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected addr %0d ord %0d st %0d, got addr %0d ord %0d st %0d",
                   want.granted_address, want.granted_order, want.status,
                   got.granted_address, got.granted_order, got.status);
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  logic      cfg_wr_en;
  logic      cfg_wr_data;

  alloc_scoreboard sb;
  bit          calm;
  int          quiet_cycles;
  int          stall_left;
  int unsigned live[$];

  buddy_block_allocator uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // result side: random stall bursts, check every accepted beat
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    if (calm || !rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 4);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send(in_item_t it);
    out_item_t   r;
    int          gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    r = sb.note_request(it);
    if (it.func == FUNC_ALLOC && r.status == ST_OK) live.push_back(r.granted_address);
    if (it.func == FUNC_FREE) begin
      foreach (live[i]) if (live[i] == it.block_address) begin
        live.delete(i);
        break;
      end
    end
  endtask

  task automatic alloc(int unsigned bytes);
    in_item_t it;
    it.func = FUNC_ALLOC;
    it.req_size = bytes[SIZE_FIELD_W-1:0];
    it.block_address = ADDR_FIELD_W'($urandom);
    send(it);
  endtask

  task automatic free_at(int unsigned addr);
    in_item_t it;
    it.func = FUNC_FREE;
    it.req_size = SIZE_FIELD_W'($urandom);
    it.block_address = addr[ADDR_FIELD_W-1:0];
    send(it);
  endtask

  task automatic set_fit(bit mode);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= mode;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.first_fit = mode;
  endtask

  task automatic random_phase(int count);
    int unsigned pick, ord;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (live.size() != 0 && pick < 45) begin
        free_at(live[$urandom_range(0, live.size() - 1)]);
      end else if (pick < 50) begin
        free_at($urandom_range(0, GRANULES - 1));
      end else if (pick < 54) begin
        alloc($urandom_range(0, 8191));
      end else begin
        // small orders mostly, so splits and merges go deep
        ord = $urandom_range(GR_ORDER - 1, PG_ORDER - 2);
        if ($urandom_range(0, 9) == 0) ord = PG_ORDER;
        alloc($urandom_range((1 << ord) / 2 + 1, 1 << ord));
      end
    end
  endtask

  initial begin
    int unsigned pages[$];
    sb = new();
    calm = 0;
    quiet_cycles = 0;
    stall_left = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    out_stall <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    set_fit(1'b0);
    // edge sizes, oversize and bad frees
    alloc(0);
    alloc(1);
    alloc(16);
    alloc(17);
    alloc(4097);
    alloc(8191);
    free_at(1023);
    free_at(live[0]);
    free_at(live[0]);
    free_at(live[0]);
    free_at(0);
    // ask for every page though page 0 is partly in use, two more, free the pages
    repeat (PAGES) begin
      alloc(4096);
      pages.push_back(live[$]);
    end
    alloc(16);
    alloc(2049);
    foreach (pages[i]) free_at(pages[i]);
    alloc(100);
    alloc(3000);
    free_at(live[0]);
    free_at(live[0]);

    set_fit(1'b1);
    random_phase(150);
    set_fit(1'b0);
    random_phase(150);
    set_fit(1'b1);
    random_phase(140);
    calm = 1;
    random_phase(60);
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
